// ===== design/quadratic_equation_solver_defines.svh =====
// ----------------------------------------------------------------------------
// Quadratic solver check macros
// Assertion helpers shared by the solver RTL.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_EQUATION_SOLVER_DEFINES_SVH
`define QUADRATIC_EQUATION_SOLVER_DEFINES_SVH

// same-cycle implication
`define QES_CHECK_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("quadratic solver check failed");

// next-cycle implication
`define QES_CHECK_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("quadratic solver check failed");

`endif

// ===== design/qes_pkg.sv =====
// ----------------------------------------------------------------------------
// Quadratic solver package
// Widths, class codes, register indexes and divider interface types.
// ----------------------------------------------------------------------------
package qes_pkg;

    localparam int COEF_W    = 32;
    localparam int CTOL_W    = 16;
    localparam int DTOL_W    = 63;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 64;

    localparam logic [DTOL_W-1:0]    DTOL_RESET   = 63'd429;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_TOL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISC_TOL = 2'd1;

    localparam int MAG_W    = 32;          // |coef| up to 2^31
    localparam int DISC_W   = 66;          // |D| below 2^65, even for the root pairs
    localparam int ROOT_W   = 33;          // floor sqrt of DISC_W bits
    localparam int SQ_STEPS = DISC_W / 2;
    localparam int NUM_W    = 34;          // |-b +/- s|
    localparam int DEN_W    = 33;          // 2|a|
    localparam int QUO_W    = 33;          // quotient bits before saturation
    localparam int DIV_LAT  = QUO_W + 2;

    typedef enum logic [2:0] {
        CLS_INF  = 3'd0,
        CLS_NONE = 3'd1,
        CLS_LIN  = 3'd2,
        CLS_CPLX = 3'd3,
        CLS_ONE  = 3'd4,
        CLS_TWO  = 3'd5
    } t_class;

    typedef struct packed {
        logic [NUM_W-1:0] nmag;
        logic [DEN_W-1:0] dmag;
        logic             neg;
    } t_div_req;

    typedef struct packed {
        logic [COEF_W-1:0] root;
        logic              ovf;
    } t_div_rsp;

endpackage

// ===== design/quadratic_equation_solver.sv =====
// Throughput: one coefficient set per cycle; the whole pipeline holds while
// the output beat is stalled. Depth is set by the 33-stage square root and
// the two 35-stage dividers running side by side.
// Reset (synchronous, active low) empties the pipeline and loads the
// tolerances with 0 and 429.
// ----------------------------------------------------------------------------
// Quadratic equation solver
// Real roots of a*x^2+b*x+c=0 in fixed point, fully pipelined.
// ----------------------------------------------------------------------------
`include "quadratic_equation_solver_defines.svh"

module quadratic_equation_solver import qes_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [95:0]          i_s_tdata,  // coef_quad, coef_lin, coef_const
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [63:0]          o_m_tdata,  // root_first, root_second
    output logic [3:0]           o_m_tuser   // solve_class, overflow
);

    localparam int TOTAL = 4 + SQ_STEPS + 1 + DIV_LAT + 1;
    localparam int RW    = ROOT_W + 2;

    typedef struct packed {
        t_class           cls;
        logic             quad;
        logic [MAG_W-1:0] ma;
        logic [MAG_W-1:0] mb;
        logic [MAG_W-1:0] mc;
        logic             sa;
        logic             sb;
        logic             sc;
        logic             czero;
        logic             c_pos;
        logic             b_pos;
    } t_side;

    logic [CTOL_W-1:0] r_coef_tol;
    logic [DTOL_W-1:0] r_disc_tol;
    logic [TOTAL-1:0]  r_vld;
    logic              en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_tol <= '0;
            r_disc_tol <= DTOL_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_COEF_TOL: r_coef_tol <= i_cfg_data[CTOL_W-1:0];
                CFG_DISC_TOL: r_disc_tol <= i_cfg_data[DTOL_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign en          = !r_vld[TOTAL-1] || i_m_tready;
    assign o_s_tready  = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[TOTAL-2:0], i_s_tvalid};
        end
    end

    // stage 1: magnitudes and zero tests
    logic [COEF_W-1:0] a_in, b_in, c_in;
    t_side             n_s1, r_s1;
    logic              za, zb, zc;

    always_comb begin
        a_in       = i_s_tdata[31:0];
        b_in       = i_s_tdata[63:32];
        c_in       = i_s_tdata[95:64];
        n_s1.sa    = a_in[COEF_W-1];
        n_s1.sb    = b_in[COEF_W-1];
        n_s1.sc    = c_in[COEF_W-1];
        n_s1.ma    = n_s1.sa ? (~a_in + MAG_W'(1)) : a_in;
        n_s1.mb    = n_s1.sb ? (~b_in + MAG_W'(1)) : b_in;
        n_s1.mc    = n_s1.sc ? (~c_in + MAG_W'(1)) : c_in;
        n_s1.czero = c_in == '0;
        n_s1.c_pos = !n_s1.sc && !n_s1.czero;
        n_s1.b_pos = !n_s1.sb && (b_in != '0);
        za         = n_s1.ma <= MAG_W'(r_coef_tol);
        zb         = n_s1.mb <= MAG_W'(r_coef_tol);
        zc         = n_s1.mc <= MAG_W'(r_coef_tol);
        n_s1.quad  = !za;
        if (!zb)     n_s1.cls = CLS_LIN;
        else if (zc) n_s1.cls = CLS_INF;
        else         n_s1.cls = CLS_NONE;
    end

    always_ff @(posedge i_clk) begin
        if (en) r_s1 <= n_s1;
    end

    // stage 2: b^2 and a*c
    logic [2*MAG_W-1:0] r_bsq, r_ac;
    t_side              r_s2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_bsq <= r_s1.mb * r_s1.mb;
            r_ac  <= r_s1.ma * r_s1.mc;
            r_s2  <= r_s1;
        end
    end

    // stage 3: |D| and its sign
    logic [DISC_W-1:0] ac4, bsq_x, n_dm, r_dm;
    logic              n_dneg, r_dneg;
    t_side             r_s3;

    always_comb begin
        ac4    = {r_ac, 2'b00};
        bsq_x  = DISC_W'(r_bsq);
        n_dneg = 1'b0;
        if (r_s2.czero || (r_s2.sa != r_s2.sc)) begin
            n_dm = bsq_x + ac4;
        end else if (bsq_x < ac4) begin
            n_dneg = 1'b1;
            n_dm   = ac4 - bsq_x;
        end else begin
            n_dm = bsq_x - ac4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dm   <= n_dm;
            r_dneg <= n_dneg;
            r_s3   <= r_s2;
        end
    end

    // stage 4: classify against tolerance, enters the square root
    logic [DISC_W-1:0] r_sd    [0:SQ_STEPS];
    t_side             r_sside [0:SQ_STEPS];
    logic [RW-1:0]     r_srem  [1:SQ_STEPS];
    logic [ROOT_W-1:0] r_sroot [1:SQ_STEPS];
    t_side             n_s4;
    logic              gt;

    always_comb begin
        n_s4 = r_s3;
        gt   = r_dm > DISC_W'(r_disc_tol);
        if (r_s3.quad) begin
            if (r_dneg && gt) n_s4.cls = CLS_CPLX;
            else if (!gt)     n_s4.cls = CLS_ONE;
            else              n_s4.cls = CLS_TWO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd[0]    <= r_dm;
            r_sside[0] <= n_s4;
        end
    end

    // square root, two radicand bits per stage
    for (genvar j = 1; j <= SQ_STEPS; j++) begin : g_sqrt
        logic [RW-1:0]     prev_rem;
        logic [ROOT_W-1:0] prev_root;
        logic [RW+1:0]     n_trial, n_test;
        logic              n_take;

        if (j == 1) begin : g_first
            assign prev_rem  = '0;
            assign prev_root = '0;
        end else begin : g_next
            assign prev_rem  = r_srem[j-1];
            assign prev_root = r_sroot[j-1];
        end

        always_comb begin
            n_trial = {prev_rem, r_sd[j-1][DISC_W-2*j+1 -: 2]};
            n_test  = (RW+2)'({prev_root, 2'b01});
            n_take  = n_trial >= n_test;
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_srem[j]  <= n_take ? RW'(n_trial - n_test) : n_trial[RW-1:0];
                r_sroot[j] <= {prev_root[ROOT_W-2:0], n_take};
                r_sd[j]    <= r_sd[j-1];
                r_sside[j] <= r_sside[j-1];
            end
        end
    end

    // numerator and denominator selection
    t_side                   sq;
    logic signed [NUM_W:0]   bval, sval, n1, n2;
    logic        [NUM_W:0]   n1m, n2m;
    t_div_req                n_req1, n_req2, r_req1, r_req2;
    t_class                  r_ncls;

    always_comb begin
        sq     = r_sside[SQ_STEPS];
        bval   = sq.sb ? -$signed((NUM_W+1)'(sq.mb)) : $signed((NUM_W+1)'(sq.mb));
        sval   = $signed((NUM_W+1)'(r_sroot[SQ_STEPS]));
        n1     = sval - bval;
        n2     = -bval - sval;
        n1m    = n1[NUM_W] ? -n1 : n1;
        n2m    = n2[NUM_W] ? -n2 : n2;
        n_req1 = '0;
        n_req2 = '0;
        case (sq.cls)
            CLS_LIN: begin
                n_req1.nmag = NUM_W'(sq.mc);
                n_req1.dmag = DEN_W'(sq.mb);
                n_req1.neg  = sq.c_pos ^ sq.sb;
            end
            CLS_ONE: begin
                n_req1.nmag = NUM_W'(sq.mb);
                n_req1.dmag = {sq.ma, 1'b0};
                n_req1.neg  = sq.b_pos ^ sq.sa;
            end
            CLS_TWO: begin
                n_req1.nmag = n1m[NUM_W-1:0];
                n_req1.dmag = {sq.ma, 1'b0};
                n_req1.neg  = n1[NUM_W] ^ sq.sa;
                n_req2.nmag = n2m[NUM_W-1:0];
                n_req2.dmag = {sq.ma, 1'b0};
                n_req2.neg  = n2[NUM_W] ^ sq.sa;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_req1 <= n_req1;
            r_req2 <= n_req2;
            r_ncls <= sq.cls;
        end
    end

    t_div_rsp rsp1, rsp2;
    t_class   r_dcls [0:DIV_LAT-1];

    qes_div #(.FRAC_BITS(FRAC_BITS)) u_div_first (
        .i_clk (i_clk),
        .i_en  (en),
        .i_req (r_req1),
        .o_rsp (rsp1)
    );

    qes_div #(.FRAC_BITS(FRAC_BITS)) u_div_second (
        .i_clk (i_clk),
        .i_en  (en),
        .i_req (r_req2),
        .o_rsp (rsp2)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dcls[0] <= r_ncls;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_dcls[i] <= r_dcls[i-1];
            end
        end
    end

    // output register
    t_class            ocls;
    logic              use1, use2;
    logic [COEF_W-1:0] r_root1, r_root2;
    logic              r_ovf;
    t_class            r_ocls;

    always_comb begin
        ocls = r_dcls[DIV_LAT-1];
        use2 = ocls == CLS_TWO;
        use1 = use2 || (ocls == CLS_LIN) || (ocls == CLS_ONE);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ocls  <= ocls;
            r_root1 <= use1 ? rsp1.root : '0;
            r_root2 <= use2 ? rsp2.root : '0;
            r_ovf   <= (use1 && rsp1.ovf) || (use2 && rsp2.ovf);
        end
    end

    assign o_m_tvalid = r_vld[TOTAL-1];
    assign o_m_tdata  = {r_root2, r_root1};
    assign o_m_tuser  = {r_ovf, r_ocls};

    `QES_CHECK_IMP(a_second_zero, i_clk, i_rst_n,
        o_m_tvalid && (o_m_tuser[2:0] != CLS_TWO), o_m_tdata[63:32] == '0)
    `QES_CHECK_IMP(a_rootless_clean, i_clk, i_rst_n,
        o_m_tvalid && (o_m_tuser[2:0] == CLS_INF || o_m_tuser[2:0] == CLS_NONE ||
        o_m_tuser[2:0] == CLS_CPLX), o_m_tdata[31:0] == '0 && !o_m_tuser[3])
    `QES_CHECK_IMP(a_ready_when_empty, i_clk, i_rst_n, !o_m_tvalid, o_s_tready)
    `QES_CHECK_NXT(a_stall_keeps_beat, i_clk, i_rst_n, !o_s_tready, o_m_tvalid)

endmodule

// ===== design/qes_div.sv =====
// ----------------------------------------------------------------------------
// Quadratic solver divider
// Pipelined rounded fixed-point divide, one quotient bit per stage, saturating.
// ----------------------------------------------------------------------------
module qes_div import qes_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_en,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int NW = NUM_W + FRAC_BITS + 1;

    logic [NW-1:0]    n_num;
    logic             n_big;

    logic [DEN_W-1:0] r_rem [0:QUO_W];
    logic [QUO_W-1:0] r_low [0:QUO_W];
    logic [QUO_W-1:0] r_quo [0:QUO_W];
    logic [DEN_W-1:0] r_den [0:QUO_W];
    logic             r_neg [0:QUO_W];
    logic             r_big [0:QUO_W];

    logic [QUO_W-1:0] n_lim;
    logic [QUO_W-1:0] n_val;
    logic             n_sat;
    t_div_rsp         r_rsp;

    always_comb begin
        n_num = (NW'(i_req.nmag) << FRAC_BITS) + NW'(i_req.dmag[DEN_W-1:1]);
        n_big = DEN_W'(n_num[NW-1:QUO_W]) >= i_req.dmag;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= DEN_W'(n_num[NW-1:QUO_W]);
            r_low[0] <= n_num[QUO_W-1:0];
            r_quo[0] <= '0;
            r_den[0] <= i_req.dmag;
            r_neg[0] <= i_req.neg;
            r_big[0] <= n_big;
        end
    end

    for (genvar k = 1; k <= QUO_W; k++) begin : g_step
        logic [DEN_W:0]   n_trial;
        logic             n_take;
        logic [DEN_W:0]   n_diff;

        always_comb begin
            n_trial = {r_rem[k-1], r_low[k-1][QUO_W-k]};
            n_take  = n_trial >= {1'b0, r_den[k-1]};
            n_diff  = n_trial - {1'b0, r_den[k-1]};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_take ? n_diff[DEN_W-1:0] : n_trial[DEN_W-1:0];
                r_quo[k] <= {r_quo[k-1][QUO_W-2:0], n_take};
                r_low[k] <= r_low[k-1];
                r_den[k] <= r_den[k-1];
                r_neg[k] <= r_neg[k-1];
                r_big[k] <= r_big[k-1];
            end
        end
    end

    always_comb begin
        n_lim = r_neg[QUO_W] ? (QUO_W'(1) << (COEF_W-1))
                             : ((QUO_W'(1) << (COEF_W-1)) - QUO_W'(1));
        n_sat = r_big[QUO_W] || (r_quo[QUO_W] > n_lim);
        n_val = n_sat ? n_lim : r_quo[QUO_W];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rsp.root <= r_neg[QUO_W] ? (COEF_W'(0) - n_val[COEF_W-1:0])
                                       : n_val[COEF_W-1:0];
            r_rsp.ovf  <= n_sat;
        end
    end

    assign o_rsp = r_rsp;

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// Quadratic solver testbench
// Streams coefficient sets into the solver under random sender gaps and
// receiver stalls, predicts class and roots with 128-bit arithmetic and
// checks every output beat in order. Runs several tolerance settings.
// ----------------------------------------------------------------------------
module testbench;
    import qes_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
    localparam int FRAC = 16;
    localparam int DRAIN_CYCLES = 120;
    localparam int PHASE_SETS = 360;

    typedef logic signed [127:0] t_wide;

    typedef struct {
        t_class      cls;
        logic [31:0] r1;
        logic [31:0] r2;
        logic        ovf;
    } t_solution;

    typedef struct {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic        known;
        t_solution   sol;
    } t_dir_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [95:0]          i_s_tdata;  // coef_quad, coef_lin, coef_const
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [63:0]          o_m_tdata;  // root_first, root_second
    logic [3:0]           o_m_tuser;  // solve_class, overflow

    quadratic_equation_solver i_dut (.*);

    logic [15:0] coef_tol;
    logic [62:0] disc_tol;
    t_solution   pending_roots[$];
    int          mismatches;
    int          sets_solved;
    int          class_seen[6];
    bit          stall_free;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic [31:0] scaled_quotient(t_wide nmag, bit neg, t_wide dmag,
                                                    inout logic ovf);
        t_wide q;
        t_wide lim;
        q = ((nmag <<< FRAC) + (dmag >>> 1)) / dmag;
        lim = neg ? t_wide'(64'h8000_0000) : t_wide'(64'h7FFF_FFFF);
        if (q > lim) begin
            q = lim;
            ovf = 1'b1;
        end
        return neg ? 32'(-q) : 32'(q);
    endfunction

    function automatic t_solution solve_roots(logic [31:0] ra, logic [31:0] rb,
                                              logic [31:0] rc);
        t_solution s;
        t_wide a, b, c, ma, mb, mc, disc, dm, sq, t, n1, n2;
        a = t_wide'($signed(ra));
        b = t_wide'($signed(rb));
        c = t_wide'($signed(rc));
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        mc = c < 0 ? -c : c;
        s = '{CLS_INF, 32'd0, 32'd0, 1'b0};
        if (ma <= coef_tol) begin
            if (mb <= coef_tol) begin
                s.cls = (mc <= coef_tol) ? CLS_INF : CLS_NONE;
            end else begin
                s.cls = CLS_LIN;
                s.r1 = scaled_quotient(mc, (c > 0) != (b < 0), mb, s.ovf);
            end
        end else begin
            disc = b * b - 4 * a * c;
            dm = disc < 0 ? -disc : disc;
            if (disc < 0 && dm > disc_tol) begin
                s.cls = CLS_CPLX;
            end else if (dm <= disc_tol) begin
                s.cls = CLS_ONE;
                s.r1 = scaled_quotient(mb, (b > 0) != (a < 0), 2 * ma, s.ovf);
            end else begin
                sq = 0;
                for (int k = 32; k >= 0; k--) begin
                    t = sq | (t_wide'(1) <<< k);
                    if (t * t <= dm) sq = t;
                end
                n1 = -b + sq;
                n2 = -b - sq;
                s.cls = CLS_TWO;
                s.r1 = scaled_quotient(n1 < 0 ? -n1 : n1, (n1 < 0) != (a < 0), 2 * ma, s.ovf);
                s.r2 = scaled_quotient(n2 < 0 ? -n2 : n2, (n2 < 0) != (a < 0), 2 * ma, s.ovf);
            end
        end
        return s;
    endfunction

    // receiver stall pattern: the mode is redrawn when a random countdown runs out
    int stall_mode;
    int mode_left;
    always @(negedge i_clk) begin
        logic ready_next;
        if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left <= $urandom_range(50, 300);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            0: ready_next = 1'b1;
            1: ready_next = ($urandom_range(0, 1) == 1);
            2: ready_next = ($urandom_range(0, 9) == 0);
            default: ready_next = (mode_left % 16) < 12;
        endcase
        i_m_tready <= ready_next || stall_free;
    end

    always @(posedge i_clk) begin
        t_solution e;
        logic [31:0] r1, r2;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            r1 = o_m_tdata[31:0];
            r2 = o_m_tdata[63:32];
            if (pending_roots.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: class %0d r1 %h r2 %h ovf %b",
                             o_m_tuser[2:0], r1, r2, o_m_tuser[3]);
            end else begin
                e = pending_roots.pop_front();
                if (e.cls !== o_m_tuser[2:0] || e.r1 !== r1 || e.r2 !== r2
                        || e.ovf !== o_m_tuser[3]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp class %0d r1 %h r2 %h ovf %b, got %0d %h %h %b",
                                 e.cls, e.r1, e.r2, e.ovf,
                                 o_m_tuser[2:0], r1, r2, o_m_tuser[3]);
                end
                sets_solved++;
                class_seen[e.cls]++;
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_COEF_TOL) coef_tol = val[15:0];
        else if (idx == CFG_DISC_TOL) disc_tol = val[62:0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_roots.size() != 0) @(posedge i_clk);
    endtask

    int gap_left;
    int burst_left;

    // beat stays raised across a burst; only lowered for a gap
    task automatic send_set(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                            bit known, t_solution sol);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
        burst_left--;
        if (gap_left > 0) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
            repeat (gap_left - 1) @(negedge i_clk);
            gap_left = 0;
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {c, b, a};
        do @(posedge i_clk); while (!o_s_tready);
        pending_roots.push_back(known ? sol : solve_roots(a, b, c));
    endtask

    task automatic idle_sender();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
    endtask

    function automatic logic [31:0] small_signed(int lim);
        return 32'($signed($urandom_range(0, 2 * lim)) - lim);
    endfunction

    task automatic random_set();
        logic [31:0] a, b, c;
        int k, p, q, m;
        t_solution none;
        none = '{CLS_INF, 32'd0, 32'd0, 1'b0};
        k = $urandom_range(1, 2000) * (($urandom_range(0, 1) == 1) ? -1 : 1);
        p = $signed(small_signed(1000));
        q = $signed(small_signed(1000));
        case ($urandom_range(0, 9))
            0, 1: begin
                a = $urandom;
                b = $urandom;
                c = $urandom;
            end
            2: begin
                a = small_signed(coef_tol + 2);
                b = small_signed(coef_tol + 2);
                c = small_signed(coef_tol + 2);
            end
            3: begin
                a = small_signed(coef_tol + 1);
                b = $urandom;
                c = $urandom;
            end
            4, 5: begin
                a = k;
                b = -k * (p + q);
                c = k * p * q;
            end
            6: begin
                m = $signed(small_signed(400));
                a = k;
                b = 2 * k * m;
                c = k * m * m + $signed(small_signed(3));
            end
            7: begin
                a = k * $urandom_range(1, 500);
                b = small_signed(2000);
                c = a * $urandom_range(1, 50);
            end
            default: begin
                a = small_signed(100000);
                b = small_signed(1000000);
                c = small_signed(100000000);
            end
        endcase
        send_set(a, b, c, 1'b0, none);
    endtask

    t_dir_row dir_tab[12];

    initial begin
        logic [CFG_DAT_W-1:0] tol_sets[5][2];
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_m_tready = 1'b0;
        stall_mode = 0;
        mode_left = 0;
        stall_free = 1'b0;
        mismatches = 0;
        sets_solved = 0;
        coef_tol = '0;
        disc_tol = DTOL_RESET;
        gap_left = 0;
        burst_left = 0;

        dir_tab[0]  = '{32'd0, 32'd0, 32'd0, 1, '{CLS_INF, 32'd0, 32'd0, 1'b0}};
        dir_tab[1]  = '{32'd0, 32'd0, 32'd1, 1, '{CLS_NONE, 32'd0, 32'd0, 1'b0}};
        dir_tab[2]  = '{32'd0, 32'h0001_0000, 32'h0001_0000, 1,
                        '{CLS_LIN, 32'hFFFF_0000, 32'd0, 1'b0}};
        dir_tab[3]  = '{32'd0, 32'd1, 32'h7FFF_FFFF, 1,
                        '{CLS_LIN, 32'h8000_0000, 32'd0, 1'b1}};
        dir_tab[4]  = '{32'h0001_0000, 32'd0, 32'h0001_0000, 1,
                        '{CLS_CPLX, 32'd0, 32'd0, 1'b0}};
        dir_tab[5]  = '{32'h0001_0000, 32'hFFFE_0000, 32'h0001_0000, 1,
                        '{CLS_ONE, 32'h0001_0000, 32'd0, 1'b0}};
        dir_tab[6]  = '{32'h0001_0000, 32'd0, 32'hFFFF_0000, 1,
                        '{CLS_TWO, 32'h0001_0000, 32'hFFFF_0000, 1'b0}};
        dir_tab[7]  = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, dir_tab[0].sol};
        dir_tab[8]  = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, dir_tab[0].sol};
        dir_tab[9]  = '{32'd1, 32'h8000_0000, 32'd0, 0, dir_tab[0].sol};
        dir_tab[10] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, dir_tab[0].sol};
        dir_tab[11] = '{32'd0, 32'h8000_0000, 32'h8000_0000, 0, dir_tab[0].sol};

        tol_sets[0] = '{64'd0, 64'(DTOL_RESET)};
        tol_sets[1] = '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF};
        tol_sets[2] = '{64'd0, 64'd0};
        tol_sets[3] = '{64'd200, 64'h0000_0100_0000_0000};
        tol_sets[4] = '{64'd0, 64'd429};

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i])
            send_set(dir_tab[i].a, dir_tab[i].b, dir_tab[i].c, dir_tab[i].known,
                     dir_tab[i].sol);

        for (int ph = 0; ph < 5; ph++) begin
            if (ph > 0) begin
                idle_sender();
                wait_drained();
                tol_sets[ph][0] = (ph == 4) ? 64'($urandom) : tol_sets[ph][0];
                tol_sets[ph][1] = (ph == 4) ? {$urandom, $urandom} : tol_sets[ph][1];
                write_reg(CFG_COEF_TOL, tol_sets[ph][0]);
                write_reg(CFG_DISC_TOL, tol_sets[ph][1]);
                if (ph == 3) begin
                    write_reg(CFG_SPARE_LO, {$urandom, $urandom});
                    write_reg(CFG_SPARE_HI, {$urandom, $urandom});
                end
            end
            for (int n = 0; n < PHASE_SETS; n++) begin
                if (ph == 1 && n == PHASE_SETS / 2) begin
                    idle_sender();
                    wait_drained();
                end
                stall_free = (ph == 2 && n < 60);
                random_set();
            end
        end
        idle_sender();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_roots.size() != 0) mismatches++;
        $display("solved %0d sets over 5 tolerance settings, %0d mismatches", sets_solved,
                 mismatches);
        $display("classes inf/none/lin/cplx/one/two: %0d %0d %0d %0d %0d %0d",
                 class_seen[0], class_seen[1], class_seen[2], class_seen[3],
                 class_seen[4], class_seen[5]);
        if (mismatches == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("testbench: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/qes_pkg.sv
design/qes_div.sv
design/quadratic_equation_solver.sv
test/testbench.sv
